// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants for the shell syntax span classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

   localparam int POS_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int START_W           = 16;
   localparam int LENGTH_W          = 17;

   typedef enum logic [1:0] {
      KIND_PLAIN   = 2'd0,
      KIND_STRING  = 2'd1,
      KIND_COMMENT = 2'd2,
      KIND_OPER    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      Q_NONE   = 2'd0,
      Q_SINGLE = 2'd1,
      Q_DOUBLE = 2'd2
   } quote_type;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_AMP       = 8'h26;
   localparam logic [7:0] CH_PIPE      = 8'h7C;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_GT        = 8'h3E;
   localparam logic [7:0] CH_LT        = 8'h3C;

   // Lexical state carried from one byte to the next.
   typedef struct packed {
      quote_type  quote;
      logic       escape;
      logic       comment;
      logic [7:0] prev_byte;
   } lex_state_type;

   typedef struct packed {
      logic [START_W-1:0]  start;
      logic [LENGTH_W-1:0] length;
      kind_type            kind;
      logic                final_span;
      logic                last_of_item;
      logic                overflow;
   } span_type;

endpackage

`default_nettype wire

// ===== sv/ssc_classify.sv =====
// ----------------------------------------------------------------------------
// ssc_classify
// Classifies one text byte and works out the lexical state for the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssc_classify (
   input  wire logic [7:0]            text_byte,
   input  wire ssc_pkg::lex_state_type state_cur,
   output ssc_pkg::kind_type          kind,
   output ssc_pkg::lex_state_type     state_nxt
);

   logic is_oper;
   logic word_start;

   always_comb begin
      is_oper = (text_byte == ssc_pkg::CH_PIPE)   || (text_byte == ssc_pkg::CH_AMP)    ||
                (text_byte == ssc_pkg::CH_SEMI)   || (text_byte == ssc_pkg::CH_GT)     ||
                (text_byte == ssc_pkg::CH_LT)     || (text_byte == ssc_pkg::CH_LPAREN) ||
                (text_byte == ssc_pkg::CH_RPAREN);
      // A zero previous byte stands for the start of the text.
      word_start = (state_cur.prev_byte == ssc_pkg::CH_NUL)     ||
                   (state_cur.prev_byte == ssc_pkg::CH_SPACE)   ||
                   (state_cur.prev_byte == ssc_pkg::CH_TAB)     ||
                   (state_cur.prev_byte == ssc_pkg::CH_NEWLINE) ||
                   (state_cur.prev_byte == ssc_pkg::CH_SEMI)    ||
                   (state_cur.prev_byte == ssc_pkg::CH_AMP)     ||
                   (state_cur.prev_byte == ssc_pkg::CH_PIPE)    ||
                   (state_cur.prev_byte == ssc_pkg::CH_LPAREN);
   end

   always_comb begin
      state_nxt           = state_cur;
      state_nxt.prev_byte = text_byte;
      kind                = ssc_pkg::KIND_PLAIN;
      if (state_cur.escape) begin
         state_nxt.escape = 1'b0;
         if ((state_cur.quote == ssc_pkg::Q_SINGLE) || (state_cur.quote == ssc_pkg::Q_DOUBLE))
            kind = ssc_pkg::KIND_STRING;
         else
            kind = ssc_pkg::KIND_PLAIN;
      end else if (state_cur.quote == ssc_pkg::Q_SINGLE) begin
         kind = ssc_pkg::KIND_STRING;
         if (text_byte == ssc_pkg::CH_SQUOTE)
            state_nxt.quote = ssc_pkg::Q_NONE;
      end else if (state_cur.quote == ssc_pkg::Q_DOUBLE) begin
         kind = ssc_pkg::KIND_STRING;
         if (text_byte == ssc_pkg::CH_BACKSLASH)
            state_nxt.escape = 1'b1;
         else if (text_byte == ssc_pkg::CH_DQUOTE)
            state_nxt.quote = ssc_pkg::Q_NONE;
      end else if (state_cur.comment) begin
         // The newline that closes a comment is itself plain.
         if (text_byte == ssc_pkg::CH_NEWLINE) begin
            state_nxt.comment = 1'b0;
            kind              = ssc_pkg::KIND_PLAIN;
         end else begin
            kind = ssc_pkg::KIND_COMMENT;
         end
      end else if (text_byte == ssc_pkg::CH_BACKSLASH) begin
         state_nxt.escape = 1'b1;
         kind             = ssc_pkg::KIND_PLAIN;
      end else if (text_byte == ssc_pkg::CH_SQUOTE) begin
         state_nxt.quote = ssc_pkg::Q_SINGLE;
         kind            = ssc_pkg::KIND_STRING;
      end else if (text_byte == ssc_pkg::CH_DQUOTE) begin
         state_nxt.quote = ssc_pkg::Q_DOUBLE;
         kind            = ssc_pkg::KIND_STRING;
      end else if ((text_byte == ssc_pkg::CH_HASH) && word_start) begin
         state_nxt.comment = 1'b1;
         kind              = ssc_pkg::KIND_COMMENT;
      end else if (is_oper) begin
         kind = ssc_pkg::KIND_OPER;
      end else begin
         kind = ssc_pkg::KIND_PLAIN;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ssc_span_queue.sv =====
// ----------------------------------------------------------------------------
// ssc_span_queue
// Small span queue: takes up to two spans a cycle and hands out one a beat while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssc_span_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push0,
   input  wire ssc_pkg::span_type span0,
   input  wire logic              push1,
   input  wire ssc_pkg::span_type span1,
   output logic                   busy,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output ssc_pkg::span_type      out_span
);

   localparam int Depth = ssc_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(Depth);

   ssc_pkg::span_type mem_ff [Depth];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;
   logic              pop;

   always_comb begin
      pop       = out_valid && !out_stall;
      wr_ptr_in = wr_ptr_ff + AW'(push0) + AW'(push1);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + (AW+1)'(push0) + (AW+1)'(push1) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0)
         mem_ff[wr_ptr_ff] <= span0;
      if (push1)
         mem_ff[AW'(wr_ptr_ff + AW'(1))] <= span1;
   end

   // Room for two spans is kept so that any byte can be taken.
   assign busy      = count_ff > (AW+1)'(Depth - 2);
   assign out_valid = count_ff != '0;
   assign out_span  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== sv/shell_syntax_span_classifier.sv =====
// ----------------------------------------------------------------------------
// shell_syntax_span_classifier
// Classifies shell text byte by byte and reports runs of equal kind as spans.
// ----------------------------------------------------------------------------
//   channel | prefix | beat carries
//   --------+--------+-------------------------------------------------------
//   input   | req_   | text_byte, end_of_text
//   result  | rsp_   | span_start, span_length, span_kind, final_span,
//           |        | last_of_item, position_overflow
//
// One byte is taken per cycle unless input is stalled; it is classified and its
// spans are formed in the same cycle and written into a four-entry span queue.
// A byte that yields two spans holds the result port for two beats; the
// queue stalls input only while fewer than two entries are free.
// Reset is synchronous and returns all state to the start of a text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shell_syntax_span_classifier #(
   parameter int POS_WIDTH = ssc_pkg::POS_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_text_byte,
   input  wire logic                           req_end_of_text,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [ssc_pkg::START_W-1:0]         rsp_span_start,
   output logic [ssc_pkg::LENGTH_W-1:0]        rsp_span_length,
   output logic [1:0]                          rsp_span_kind,
   output logic                                rsp_final_span,
   output logic                                rsp_last_of_item,
   output logic                                rsp_position_overflow
);

   localparam int SW = (POS_WIDTH > ssc_pkg::START_W) ? POS_WIDTH : ssc_pkg::START_W;
   localparam int LW = (POS_WIDTH + 1 > ssc_pkg::LENGTH_W) ? POS_WIDTH + 1 : ssc_pkg::LENGTH_W;

   ssc_pkg::kind_type      kind_ff, kind_in;
   ssc_pkg::lex_state_type lex_ff, lex_in;
   ssc_pkg::lex_state_type lex_nxt;
   ssc_pkg::kind_type      byte_kind;
   logic [POS_WIDTH-1:0]   begin_ff, begin_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic                   ovf_ff, ovf_in;

   logic                   accept;
   logic                   first;
   logic                   change;
   logic                   emit_closed;
   logic [POS_WIDTH-1:0]   closed_diff;
   logic [POS_WIDTH:0]     closed_len;
   logic [POS_WIDTH-1:0]   close_begin;
   ssc_pkg::kind_type      close_kind;
   logic [POS_WIDTH:0]     close_len;
   logic [SW-1:0]          closed_start_wide, close_start_wide;
   logic [LW-1:0]          closed_len_wide, close_len_wide;
   ssc_pkg::span_type      closed_span, close_span;
   ssc_pkg::span_type      slot0;
   logic                   push0, push1;
   logic                   queue_busy;
   ssc_pkg::span_type      out_span;

   ssc_classify u_classify (
      .text_byte (req_text_byte),
      .state_cur (lex_ff),
      .kind      (byte_kind),
      .state_nxt (lex_nxt)
   );

   always_comb begin
      accept      = req_valid && !req_stall;
      first       = (pos_ff == '0) && !ovf_ff;
      change      = byte_kind != kind_ff;
      emit_closed = change && !first;

      // A run that closes with equal begin and position spans the whole range.
      closed_diff = pos_ff - begin_ff;
      closed_len  = (closed_diff == '0) ? {1'b1, {POS_WIDTH{1'b0}}} : {1'b0, closed_diff};

      close_begin = change ? pos_ff : begin_ff;
      close_kind  = change ? byte_kind : kind_ff;
      close_len   = {1'b0, pos_ff - close_begin} + (POS_WIDTH+1)'(1);

      closed_start_wide = SW'(begin_ff);
      close_start_wide  = SW'(close_begin);
      closed_len_wide   = LW'(closed_len);
      close_len_wide    = LW'(close_len);

      closed_span.start        = closed_start_wide[ssc_pkg::START_W-1:0];
      closed_span.length       = closed_len_wide[ssc_pkg::LENGTH_W-1:0];
      closed_span.kind         = kind_ff;
      closed_span.final_span   = 1'b0;
      closed_span.last_of_item = !req_end_of_text;
      closed_span.overflow     = ovf_ff;

      close_span.start        = close_start_wide[ssc_pkg::START_W-1:0];
      close_span.length       = close_len_wide[ssc_pkg::LENGTH_W-1:0];
      close_span.kind         = close_kind;
      close_span.final_span   = 1'b1;
      close_span.last_of_item = 1'b1;
      close_span.overflow     = ovf_ff;

      slot0 = emit_closed ? closed_span : close_span;
      push0 = accept && (emit_closed || req_end_of_text);
      push1 = accept && emit_closed && req_end_of_text;
   end

   always_comb begin
      kind_in  = kind_ff;
      lex_in   = lex_ff;
      begin_in = begin_ff;
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_end_of_text) begin
            kind_in  = ssc_pkg::KIND_PLAIN;
            lex_in   = '0;
            begin_in = '0;
            pos_in   = '0;
            ovf_in   = 1'b0;
         end else begin
            if (change) begin
               kind_in  = byte_kind;
               begin_in = pos_ff;
            end
            lex_in = lex_nxt;
            if (pos_ff == '1)
               ovf_in = 1'b1;
            pos_in = pos_ff + POS_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= ssc_pkg::KIND_PLAIN;
         lex_ff   <= '0;
         begin_ff <= '0;
         pos_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         kind_ff  <= kind_in;
         lex_ff   <= lex_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         ovf_ff   <= ovf_in;
      end
   end

   ssc_span_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .span0     (slot0),
      .push1     (push1),
      .span1     (close_span),
      .busy      (queue_busy),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_span  (out_span)
   );

   assign req_stall             = queue_busy;
   assign rsp_span_start        = out_span.start;
   assign rsp_span_length       = out_span.length;
   assign rsp_span_kind         = out_span.kind;
   assign rsp_final_span        = out_span.final_span;
   assign rsp_last_of_item      = out_span.last_of_item;
   assign rsp_position_overflow = out_span.overflow;

endmodule

`default_nettype wire
